// ===== hw/rtl/dspw_pkg.sv =====
// ----------------------------------------------------------------------------
// dspw_pkg: shared types and constants for the date string parser
// Request record passed from the byte front end to the calendar back end,
// character codes, separator codes and the month tables.
// ----------------------------------------------------------------------------
package dspw_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] SEP_NONE  = 2'd0;
  localparam logic [1:0] SEP_SLASH = 2'd1;
  localparam logic [1:0] SEP_DASH  = 2'd2;

  localparam logic [3:0] POS_TOO_LONG = 4'd10;
  localparam logic [3:0] CNT_SAT      = 4'd11;
  localparam logic [3:0] LEN_MIN      = 4'd8;
  localparam logic [3:0] LEN_MAX      = 4'd10;
  localparam logic [3:0] MONTH_FEB    = 4'd2;
  localparam logic [3:0] MONTH_MAR    = 4'd3;
  localparam logic [4:0] FEB_LEAP_LEN = 5'd29;

  // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT for y below 2^14
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  // floor(s / 7) = (s * DIV7_MUL) >> DIV7_SHIFT for the sums that matter
  localparam logic [13:0] DIV7_MUL     = 14'd9363;
  localparam int          DIV7_SHIFT   = 16;

  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [3:0]  month;
    logic [6:0]  day;
  } dspw_rec_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] month_off(input logic [3:0] m);
    logic [2:0] off;
    case (m)
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage

// ===== hw/rtl/dspw_front.sv =====
// ----------------------------------------------------------------------------
// dspw_front: byte front end
// Accepts one character per cycle unless the queue is full, tracks separators and
// digit fields, and on the final byte emits one request record with the format verdict.
// ----------------------------------------------------------------------------
module dspw_front
  import dspw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic [7:0] in_char_code,
  input  logic      in_last_char,
  input  logic      q_full,
  output logic      push,
  output dspw_rec_t push_rec
);

  logic [3:0]  cnt_r,  cnt_nxt;
  logic [1:0]  sep_r,  sep_nxt;
  logic [2:0]  fsep_r, fsep_nxt;
  logic [3:0]  ssep_r, ssep_nxt;
  logic [13:0] yacc_r, yacc_nxt;
  logic [6:0]  macc_r, macc_nxt;
  logic [6:0]  dacc_r, dacc_nxt;
  logic        bad_r,  bad_nxt;

  logic        accept;
  logic [1:0]  kind;
  logic        is_digit;
  logic [3:0]  digit;
  logic        fmt_ok;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_digit = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);
  assign digit    = in_char_code[3:0];

  always_comb begin
    if (in_char_code == CH_SLASH) begin
      kind = SEP_SLASH;
    end else if (in_char_code == CH_DASH) begin
      kind = SEP_DASH;
    end else begin
      kind = SEP_NONE;
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    sep_nxt  = sep_r;
    fsep_nxt = fsep_r;
    ssep_nxt = ssep_r;
    yacc_nxt = yacc_r;
    macc_nxt = macc_r;
    dacc_nxt = dacc_r;
    bad_nxt  = bad_r;
    fmt_ok   = 1'b0;
    push     = 1'b0;
    push_rec = '0;
    if (accept) begin
      if (cnt_r >= POS_TOO_LONG) begin
        bad_nxt = 1'b1;
      end else if (kind != SEP_NONE) begin
        if (sep_r == SEP_NONE) begin
          sep_nxt  = kind;
          fsep_nxt = cnt_r[2:0];
          if (cnt_r < 4'd1 || cnt_r > 4'd4) begin
            bad_nxt = 1'b1;
          end
        end else if (kind != sep_r) begin
          bad_nxt = 1'b1;
        end else if (ssep_r == 4'd0) begin
          ssep_nxt = cnt_r;
          if (cnt_r != {1'b0, fsep_r} + 4'd3) begin
            bad_nxt = 1'b1;
          end
        end else begin
          bad_nxt = 1'b1;
        end
      end else if (!is_digit) begin
        bad_nxt = 1'b1;
      end else if (sep_r == SEP_NONE) begin
        if (cnt_r >= 4'd4) begin
          bad_nxt = 1'b1;
        end else begin
          yacc_nxt = 14'(yacc_r * 14'd10 + 14'(digit));
        end
      end else if (ssep_r == 4'd0) begin
        if (cnt_r >= {1'b0, fsep_r} + 4'd3) begin
          bad_nxt = 1'b1;
        end else begin
          macc_nxt = 7'(macc_r * 7'd10 + 7'(digit));
        end
      end else begin
        if (cnt_r >= ssep_r + 4'd3) begin
          bad_nxt = 1'b1;
        end else begin
          dacc_nxt = 7'(dacc_r * 7'd10 + 7'(digit));
        end
      end

      if (cnt_r < CNT_SAT) begin
        cnt_nxt = cnt_r + 4'd1;
      end

      if (in_last_char) begin
        fmt_ok = !bad_nxt && cnt_nxt >= LEN_MIN && cnt_nxt <= LEN_MAX &&
                 sep_nxt != SEP_NONE && ssep_nxt != 4'd0 &&
                 cnt_nxt == ssep_nxt + 4'd3 && fsep_nxt >= 3'd1;
        push           = 1'b1;
        push_rec.ok    = fmt_ok && yacc_nxt != 14'd0 && macc_nxt >= 7'd1 &&
                         macc_nxt <= 7'd12 && dacc_nxt >= 7'd1;
        push_rec.year  = yacc_nxt;
        push_rec.month = macc_nxt[3:0];
        push_rec.day   = dacc_nxt;
        cnt_nxt  = '0;
        sep_nxt  = SEP_NONE;
        fsep_nxt = '0;
        ssep_nxt = '0;
        yacc_nxt = '0;
        macc_nxt = '0;
        dacc_nxt = '0;
        bad_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sep_r  <= SEP_NONE;
      fsep_r <= '0;
      ssep_r <= '0;
      yacc_r <= '0;
      macc_r <= '0;
      dacc_r <= '0;
      bad_r  <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      sep_r  <= sep_nxt;
      fsep_r <= fsep_nxt;
      ssep_r <= ssep_nxt;
      yacc_r <= yacc_nxt;
      macc_r <= macc_nxt;
      dacc_r <= dacc_nxt;
      bad_r  <= bad_nxt;
    end
  end

endmodule

// ===== hw/rtl/dspw_queue.sv =====
// ----------------------------------------------------------------------------
// dspw_queue: request queue between front end and back end
// Small FIFO of parsed string records; DEPTH must be a power of two (the block does not enforce it).
// ----------------------------------------------------------------------------
module dspw_queue
  import dspw_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  dspw_rec_t push_rec,
  input  logic      pop,
  output dspw_rec_t pop_rec,
  output logic      full,
  output logic      empty
);

  localparam int AW = $clog2(DEPTH);

  dspw_rec_t     mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r,    cnt_nxt;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_rec = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/dspw_back.sv =====
// ----------------------------------------------------------------------------
// dspw_back: calendar back end
// Four-stage pipeline: century split, leap and day check with weekday sum,
// reduction mod 7, output register. All stages advance together.
// ----------------------------------------------------------------------------
module dspw_back
  import dspw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  dspw_rec_t  q_rec,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_date_ok,
  output logic [13:0] out_year_out,
  output logic [3:0] out_month_out,
  output logic [4:0] out_day_out,
  output logic [2:0] out_weekday_out
);

  logic        adv;

  // stage 1
  logic        v1_r;
  logic        ok1_r;
  logic [13:0] y1_r;
  logic [3:0]  m1_r;
  logic [6:0]  d1_r;
  logic [13:0] ya1_r;
  logic [7:0]  q1_r;
  logic [2:0]  off1_r;
  logic [4:0]  len1_r;
  logic [13:0] yadj;
  logic [26:0] prod100;

  // stage 2
  logic        v2_r;
  logic        ok2_r;
  logic [13:0] y2_r;
  logic [3:0]  m2_r;
  logic [4:0]  d2_r;
  logic [14:0] sum2_r;
  logic [13:0] r100;
  logic        leap;
  logic [4:0]  maxd;
  logic [14:0] sum_nxt;

  // stage 3
  logic        v3_r;
  logic        ok3_r;
  logic [13:0] y3_r;
  logic [3:0]  m3_r;
  logic [4:0]  d3_r;
  logic [14:0] sum3_r;
  logic [12:0] q7_r;
  logic [28:0] prod7;

  // output
  logic        ov_r;
  logic        ook_r;
  logic [13:0] oy_r;
  logic [3:0]  om_r;
  logic [4:0]  od_r;
  logic [2:0]  ow_r;
  logic [14:0] rem7;

  assign adv = !ov_r || !out_stall;
  assign pop = adv && !q_empty;

  assign yadj    = (q_rec.month < MONTH_MAR) ? q_rec.year - 14'd1 : q_rec.year;
  assign prod100 = 27'(yadj) * 27'(DIV100_MUL);

  assign r100 = ya1_r - 14'(q1_r * 14'd100);
  assign leap = (ya1_r[1:0] == 2'b11) && ((r100 != 14'd99) || (q1_r[1:0] == 2'b11));
  assign maxd = (m1_r == MONTH_FEB && leap) ? FEB_LEAP_LEN : len1_r;
  assign sum_nxt = 15'(ya1_r) + 15'(ya1_r >> 2) - 15'(q1_r) + 15'(q1_r >> 2) +
                   15'(off1_r) + 15'(d1_r);

  assign prod7 = 29'(sum2_r) * 29'(DIV7_MUL);
  assign rem7  = sum3_r - 15'(q7_r * 15'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      v1_r <= !q_empty;
      v2_r <= v1_r;
      v3_r <= v2_r;
      ov_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok1_r  <= q_rec.ok;
      y1_r   <= q_rec.year;
      m1_r   <= q_rec.month;
      d1_r   <= q_rec.day;
      ya1_r  <= yadj;
      q1_r   <= prod100[DIV100_SHIFT +: 8];
      off1_r <= month_off(q_rec.month);
      len1_r <= month_len(q_rec.month);

      ok2_r  <= ok1_r && (d1_r <= 7'(maxd));
      y2_r   <= y1_r;
      m2_r   <= m1_r;
      d2_r   <= d1_r[4:0];
      sum2_r <= sum_nxt;

      ok3_r  <= ok2_r;
      y3_r   <= y2_r;
      m3_r   <= m2_r;
      d3_r   <= d2_r;
      sum3_r <= sum2_r;
      q7_r   <= prod7[DIV7_SHIFT +: 13];

      ook_r  <= ok3_r;
      oy_r   <= ok3_r ? y3_r : '0;
      om_r   <= ok3_r ? m3_r : '0;
      od_r   <= ok3_r ? d3_r : '0;
      ow_r   <= ok3_r ? rem7[2:0] : '0;
    end
  end

  assign out_valid       = ov_r;
  assign out_date_ok     = ook_r;
  assign out_year_out    = oy_r;
  assign out_month_out   = om_r;
  assign out_day_out     = od_r;
  assign out_weekday_out = ow_r;

endmodule

// ===== hw/rtl/date_string_parse_weekday.sv =====
// ----------------------------------------------------------------------------
// date_string_parse_weekday: date string check with day of week
// Takes one character per cycle unless stalled, with a last-byte flag, and returns, per string,
// a valid flag, year, month, day and weekday (0 Sunday); zero fields if invalid.
// ----------------------------------------------------------------------------
// Throughput is one character per cycle with no gaps between strings while
// the input is not stalled. Each finished string passes through the queue and
// then the back-end pipeline (century split, leap and weekday sum, mod-7
// reduction, output register). The input stalls only when QUEUE_DEPTH
// finished strings wait in the queue in front of a stalled output.
module date_string_parse_weekday
  import dspw_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_date_ok,
  output logic [13:0] out_year_out,
  output logic [3:0]  out_month_out,
  output logic [4:0]  out_day_out,
  output logic [2:0]  out_weekday_out
);

  logic      q_full;
  logic      q_empty;
  logic      push;
  logic      pop;
  dspw_rec_t push_rec;
  dspw_rec_t pop_rec;

  dspw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .q_full       (q_full),
    .push         (push),
    .push_rec     (push_rec)
  );

  dspw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .full     (q_full),
    .empty    (q_empty)
  );

  dspw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_rec           (pop_rec),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_date_ok     (out_date_ok),
    .out_year_out    (out_year_out),
    .out_month_out   (out_month_out),
    .out_day_out     (out_day_out),
    .out_weekday_out (out_weekday_out)
  );

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for date_string_parse_weekday
// Streams date strings one byte per request, with the last byte marked, and
// predicts each string's verdict, date and weekday. Every result is compared
// field by field with the oldest prediction. Covers calendar edge cases,
// malformed strings, random noise, random idling on both sides and a long
// output hold that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
  import dspw_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int BYTE_TARGET = 1900;
  localparam int HOLD_CYCLES = 150;
  localparam int DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int MONTH_SHIFT [12]   = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  wday;
  } date_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_code = 8'h00;
  logic        in_last_char = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_date_ok;
  logic [13:0] out_year_out;
  logic [3:0]  out_month_out;
  logic [4:0]  out_day_out;
  logic [2:0]  out_weekday_out;

  // parser state mirror
  logic [3:0]  pos_cnt = '0;
  logic [1:0]  sep_mode = SEP_NONE;
  logic [2:0]  sep1_pos = '0;
  logic [3:0]  sep2_pos = '0;
  logic [13:0] yr_acc = '0;
  logic [6:0]  mo_acc = '0;
  logic [6:0]  dy_acc = '0;
  logic        str_bad = 1'b0;

  date_result_t expected_dates[$];
  date_result_t exp_r;
  logic [7:0]   str_buf[$];

  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int err_cnt = 0;
  int n_bytes = 0;
  int n_strings = 0;
  int n_results = 0;
  int n_valid = 0;
  int cyc = 0;

  date_string_parse_weekday dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_last_char   (in_last_char),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_date_ok    (out_date_ok),
    .out_year_out   (out_year_out),
    .out_month_out  (out_month_out),
    .out_day_out    (out_day_out),
    .out_weekday_out(out_weekday_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit predict_date(input logic [7:0] c, input logic last,
                                      output date_result_t r);
    int p, n, y, m, d, yy, maxd;
    logic [1:0] kind;
    bit ok;
    p = pos_cnt;
    r = '0;
    kind = (c == CH_SLASH) ? SEP_SLASH : (c == CH_DASH) ? SEP_DASH : SEP_NONE;
    if (p >= POS_TOO_LONG) begin
      str_bad = 1'b1;
    end else if (kind != SEP_NONE) begin
      if (sep_mode == SEP_NONE) begin
        sep_mode = kind;
        sep1_pos = p[2:0];
        if (p < 1 || p > 4) str_bad = 1'b1;
      end else if (kind != sep_mode) begin
        str_bad = 1'b1;
      end else if (sep2_pos == 0) begin
        sep2_pos = p[3:0];
        if (p != sep1_pos + 3) str_bad = 1'b1;
      end else begin
        str_bad = 1'b1;
      end
    end else if (c < CH_ZERO || c > CH_NINE) begin
      str_bad = 1'b1;
    end else if (sep_mode == SEP_NONE) begin
      if (p >= 4) str_bad = 1'b1;
      else yr_acc = yr_acc * 14'd10 + 14'(c - CH_ZERO);
    end else if (sep2_pos == 0) begin
      if (p >= sep1_pos + 3) str_bad = 1'b1;
      else mo_acc = mo_acc * 7'd10 + 7'(c - CH_ZERO);
    end else begin
      if (p >= sep2_pos + 3) str_bad = 1'b1;
      else dy_acc = dy_acc * 7'd10 + 7'(c - CH_ZERO);
    end
    if (pos_cnt < CNT_SAT) pos_cnt = pos_cnt + 4'd1;
    if (!last) return 1'b0;

    n = pos_cnt;
    y = yr_acc;
    m = mo_acc;
    d = dy_acc;
    ok = !str_bad && n >= LEN_MIN && n <= LEN_MAX && sep_mode != SEP_NONE &&
         sep2_pos != 0 && n == sep2_pos + 3 && sep1_pos >= 1;
    if (ok) begin
      if (y == 0 || m < 1 || m > 12 || d < 1) begin
        ok = 1'b0;
      end else begin
        maxd = DAYS_IN_MONTH[m - 1];
        if (m == MONTH_FEB && y % 4 == 0 && (y % 100 != 0 || y % 400 == 0))
          maxd = FEB_LEAP_LEN;
        if (d > maxd) ok = 1'b0;
      end
    end
    if (ok) begin
      yy = (m < MONTH_MAR) ? y - 1 : y;
      r.ok = 1'b1;
      r.year = yr_acc;
      r.month = mo_acc[3:0];
      r.day = dy_acc[4:0];
      r.wday = 3'((yy + yy / 4 - yy / 100 + yy / 400 + MONTH_SHIFT[m - 1] + d) % 7);
    end
    pos_cnt = '0;
    sep_mode = SEP_NONE;
    sep1_pos = '0;
    sep2_pos = '0;
    yr_acc = '0;
    mo_acc = '0;
    dy_acc = '0;
    str_bad = 1'b0;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [13:0] exp_v,
                             input logic [13:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // check results
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_dates.size() == 0) begin
        $display("%0t: result with no request pending, actual ok=%0b %0d-%0d-%0d wd=%0d",
                 $time, out_date_ok, out_year_out, out_month_out, out_day_out,
                 out_weekday_out);
        err_cnt++;
      end else begin
        exp_r = expected_dates.pop_front();
        if (exp_r.ok) n_valid++;
        check_field("date_ok", 14'(exp_r.ok), 14'(out_date_ok));
        check_field("year", exp_r.year, out_year_out);
        check_field("month", 14'(exp_r.month), 14'(out_month_out));
        check_field("day", 14'(exp_r.day), 14'(out_day_out));
        check_field("weekday", 14'(exp_r.wday), 14'(out_weekday_out));
      end
    end
  end

  // drive output stall: random idling plus a counted long hold
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall <= (hold_req != hold_seen) || (hold_left > 1) ||
                 (gaps_on && $urandom_range(0, 99) < 8);
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cyc, expected_dates.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic last);
    date_result_t r;
    in_valid <= 1'b1;
    in_char_code <= c;
    in_last_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_bytes++;
    if (predict_date(c, last, r)) expected_dates.push_back(r);
    if (gaps_on && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_buf(input bit mark_last);
    n_strings++;
    foreach (str_buf[i]) send_byte(str_buf[i], mark_last && (i == str_buf.size() - 1));
  endtask

  task automatic send_text(input string s, input bit mark_last = 1'b1);
    str_buf.delete();
    for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
    send_buf(mark_last);
  endtask

  task automatic wait_for_dates();
    in_valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // fill str_buf with a mostly well-formed date, sometimes broken or pure noise
  task automatic build_random_date();
    int kind, pos;
    string ys, sa, sb, s;
    int mo, dy;
    kind = $urandom_range(0, 99);
    str_buf.delete();
    if (kind < 6) begin
      repeat ($urandom_range(1, 14)) str_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(2, 4))
      2: ys = $sformatf("%02d", $urandom_range(0, 99));
      3: ys = $sformatf("%03d", $urandom_range(0, 999));
      default: begin
        if ($urandom_range(0, 3) == 0)
          ys = $sformatf("%04d", 100 * $urandom_range(0, 99) + 4 * $urandom_range(0, 1));
        else
          ys = $sformatf("%04d", $urandom_range(0, 9999));
      end
    endcase
    mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    if ($urandom_range(0, 9) == 0) dy = $urandom_range(0, 99);
    else if ($urandom_range(0, 2) == 0) dy = $urandom_range(28, 31);
    else dy = $urandom_range(1, 31);
    sa = $urandom_range(0, 1) ? "/" : "-";
    sb = sa;
    if ($urandom_range(0, 19) == 0) sb = (sa == "/") ? "-" : "/";
    s = {ys, sa, $sformatf("%02d", mo), sb, $sformatf("%02d", dy)};
    for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
    if (kind >= 82) begin
      pos = $urandom_range(0, str_buf.size() - 1);
      case ($urandom_range(0, 2))
        0: str_buf[pos] = 8'($urandom_range(0, 255));
        1: str_buf.insert(pos, $urandom_range(0, 1) ? CH_DASH : 8'(CH_ZERO + $urandom_range(0, 9)));
        default: str_buf.delete(pos);
      endcase
    end
  endtask

  task automatic test_calendar_dates();
    send_text("2024/02/29");
    send_text("2023-02-29");
    send_text("1900/02/29");
    send_text("2000-02-29");
    send_text("9999/12/31");
    send_text("0001-01-01");
    send_text("99/03/01");
    send_text("0000/01/01");
    send_text("2023/04/31");
    send_text("2023-13-01");
    send_text("2023/00/10");
    send_text("2023/04/00");
    wait_for_dates();
  endtask

  task automatic test_malformed_strings();
    send_text("2023/04-01");
    send_text("2023/04/0/");
    send_text("/023/04/01");
    send_text("2023/04/011");
    send_text("20231/04/01");
    send_text("2023/123/1");
    send_text("2a23/04/01");
    send_text("1/01/01");
    send_text("5");
    send_text("2023-01-0112345");
    send_text("12", 1'b0);
    send_text("2024/01/01");
    str_buf = '{8'hFF, 8'h00, CH_NINE, CH_SLASH, 8'hC0, 8'h7F};
    send_buf(1'b1);
    wait_for_dates();
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    repeat (30) begin
      build_random_date();
      send_buf(1'b1);
    end
    wait_for_dates();
    gaps_on = 1'b1;
  endtask

  task automatic test_output_hold();
    hold_req <= ~hold_req;
    repeat (20) begin
      build_random_date();
      send_buf(1'b1);
    end
    wait_for_dates();
  endtask

  task automatic test_random_strings();
    while (n_bytes < BYTE_TARGET) begin
      build_random_date();
      send_buf(1'b1);
    end
    wait_for_dates();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_calendar_dates();
    test_malformed_strings();
    test_back_to_back();
    test_output_hold();
    test_random_strings();
    if (expected_dates.size() != 0) begin
      $display("%0d results never arrived", expected_dates.size());
      err_cnt++;
    end
    $display("covered %0d strings over %0d bytes, %0d results of which %0d valid dates",
             n_strings, n_bytes, n_results, n_valid);
    $display("with random idling, a gap-free stretch and a long output hold; %0d errors",
             err_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
